FILE: rtl/dmx_channel_linear_fader_top_assert.svh
// Assertion macros used by the fader's top level.
`ifndef DMX_CHANNEL_LINEAR_FADER_TOP_ASSERT_SVH
`define DMX_CHANNEL_LINEAR_FADER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMXF_ASSERT_SAME(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("fader assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DMXF_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("fader assertion failed");

`endif

FILE: rtl/dmxf_pkg.sv
// Package with the fader's shared types and constants.
`default_nettype none
package dmxf_pkg;

   // Opcodes of an input item.
   localparam logic [1:0] OP_SET_TARGET = 2'd0;
   localparam logic [1:0] OP_UPDATE     = 2'd1;
   localparam logic [1:0] OP_STOP_ALL   = 2'd2;
   localparam logic [1:0] OP_CLEAR_ALL  = 2'd3;

   // Quotient bits produced by the serial divider.
   localparam int DIV_STEPS = 16;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  universe_slot;
      logic [9:0]  channel_address;
      logic [9:0]  target_level;
      logic [23:0] fade_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] level;
      logic       fading;
      logic       status;
   } rsp_type;

   // One channel's stored fade record.
   typedef struct packed {
      logic [15:0] cur_level;
      logic [15:0] start_level;
      logic [7:0]  goal_level;
      logic [31:0] start_time;
      logic [23:0] fade_length;
   } chan_type;

   localparam int CHAN_W = $bits(chan_type);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CALC,
      ST_DINIT,
      ST_DIV,
      ST_APPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sweep_start;
      logic sweep_step;
      logic calc;
      logic div_init;
      logic div_step;
      logic commit;
      logic resp_zero;
      logic resp_bad;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic       bad_addr;
      logic       need_div;
      logic       sweep_last;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/dmxf_ram.sv
// Generic single-port-write RAM with a registered read.
`default_nettype none
module dmxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [AW-1:0]        raddr,
   output logic      [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: rtl/dmxf_ctrl.sv
// Controller state machine of the fader.
`default_nettype none
module dmxf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dmxf_pkg::sts_type sts,
   output dmxf_pkg::cmd_type     cmd
);
   dmxf_pkg::state_type state_ff, state_in;
   logic [3:0] div_cnt_ff, div_cnt_in;

   // State and divider step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dmxf_pkg::ST_SWEEP;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      busy       = (state_ff != dmxf_pkg::ST_IDLE);
      case (state_ff)
         dmxf_pkg::ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = dmxf_pkg::ST_IDLE;
            end
         end
         dmxf_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = dmxf_pkg::ST_DECODE;
            end
         end
         dmxf_pkg::ST_DECODE: begin
            if (sts.opcode == dmxf_pkg::OP_STOP_ALL ||
                sts.opcode == dmxf_pkg::OP_CLEAR_ALL) begin
               cmd.resp_zero   = 1'b1;
               cmd.sweep_start = 1'b1;
               state_in        = dmxf_pkg::ST_SWEEP;
            end else if (sts.bad_addr) begin
               cmd.resp_bad = 1'b1;
               state_in     = dmxf_pkg::ST_IDLE;
            end else begin
               state_in = dmxf_pkg::ST_READ;
            end
         end
         dmxf_pkg::ST_READ: begin
            state_in = dmxf_pkg::ST_CALC;
         end
         dmxf_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = dmxf_pkg::ST_DINIT;
         end
         dmxf_pkg::ST_DINIT: begin
            div_cnt_in = '0;
            if (sts.need_div) begin
               cmd.div_init = 1'b1;
               state_in     = dmxf_pkg::ST_DIV;
            end else begin
               state_in = dmxf_pkg::ST_APPLY;
            end
         end
         dmxf_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'(dmxf_pkg::DIV_STEPS - 1)) begin
               state_in = dmxf_pkg::ST_APPLY;
            end
         end
         dmxf_pkg::ST_APPLY: begin
            cmd.commit = 1'b1;
            state_in   = dmxf_pkg::ST_IDLE;
         end
         default: begin
            state_in = dmxf_pkg::ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/dmxf_dp.sv
// Datapath of the fader: channel stores, fade arithmetic and serial divider.
`default_nettype none
module dmxf_dp #(
   parameter int CHANNELS  = 512,
   parameter int UNIVERSES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dmxf_pkg::req_type req_data,
   input  wire dmxf_pkg::cmd_type cmd,
   output dmxf_pkg::sts_type      sts,
   output logic                   rsp_valid,
   output dmxf_pkg::rsp_type      rsp_data
);
   localparam int DEPTH = CHANNELS * UNIVERSES;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   dmxf_pkg::req_type  req_ff;
   dmxf_pkg::chan_type chan_q, chan_ff, chan_wdata;
   logic               run_q, wr_q;
   logic [IDX_W-1:0]   idx, sweep_ff;
   logic               sweep_clear_ff;
   logic [1:0]         slot_sat;
   logic               wr_ff, act_ff, expired_ff, up_ff;
   logic [39:0]        prod_ff;
   logic [23:0]        dur_ff, rem_ff;
   logic [15:0]        lo_ff, quo_ff;
   logic               rsp_valid_ff;
   dmxf_pkg::rsp_type  rsp_ff;

   // Address decode of the captured item.
   always_comb begin
      slot_sat = (32'(req_ff.universe_slot) >= 32'(UNIVERSES)) ?
                 2'(UNIVERSES - 1) : req_ff.universe_slot;
      idx = IDX_W'(32'(slot_sat) * 32'(CHANNELS) +
                   32'(req_ff.channel_address) - 32'd1);
   end

   assign sts.opcode     = req_ff.opcode;
   assign sts.bad_addr   = (req_ff.channel_address == 10'd0) ||
                           (32'(req_ff.channel_address) > 32'(CHANNELS));
   assign sts.need_div   = act_ff & ~expired_ff;
   assign sts.sweep_last = (sweep_ff == IDX_W'(DEPTH - 1));

   // Elapsed time, direction and the level difference for the division.
   logic [31:0] elapsed;
   logic [23:0] dur;
   logic [15:0] goal16, diff;
   logic        up;
   always_comb begin
      elapsed = req_ff.now_ms - chan_q.start_time;
      dur     = (chan_q.fade_length == 24'd0) ? 24'd1 : chan_q.fade_length;
      goal16  = {chan_q.goal_level, 8'd0};
      up      = (goal16 >= chan_q.start_level);
      diff    = up ? (goal16 - chan_q.start_level) : (chan_q.start_level - goal16);
   end

   // One restoring division step.
   logic [24:0] trial;
   logic        trial_ge;
   assign trial    = {rem_ff, lo_ff[15]};
   assign trial_ge = (trial >= {1'b0, dur_ff});

   // Captured item, arithmetic registers and divider.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.calc) begin
         chan_ff    <= chan_q;
         wr_ff      <= wr_q;
         act_ff     <= wr_q & run_q;
         expired_ff <= (elapsed >= {8'd0, dur});
         up_ff      <= up;
         prod_ff    <= 40'(diff) * 40'(elapsed[23:0]);
         dur_ff     <= dur;
      end
      if (cmd.div_init) begin
         rem_ff <= prod_ff[39:16];
         lo_ff  <= prod_ff[15:0];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? 24'(trial - {1'b0, dur_ff}) : trial[23:0];
         lo_ff  <= {lo_ff[14:0], 1'b0};
         quo_ff <= {quo_ff[14:0], trial_ge};
      end
   end

   // Advanced level, then the new fade for a set-target item.
   logic [15:0] adv_cur, cur_base, goal_new, cur_new, fin_cur;
   logic [7:0]  lvl_sat;
   logic        adv_run, run_new, fin_run, fin_wr, is_set;
   logic [16:0] round_sum;
   always_comb begin
      is_set = (req_ff.opcode == dmxf_pkg::OP_SET_TARGET);
      if (!act_ff) begin
         adv_cur = chan_ff.cur_level;
      end else if (expired_ff) begin
         adv_cur = {chan_ff.goal_level, 8'd0};
      end else if (up_ff) begin
         adv_cur = chan_ff.start_level + quo_ff;
      end else begin
         adv_cur = chan_ff.start_level - quo_ff;
      end
      adv_run  = act_ff & ~expired_ff;
      cur_base = wr_ff ? adv_cur : 16'd0;
      lvl_sat  = (req_ff.target_level > 10'd255) ? 8'd255 : req_ff.target_level[7:0];
      goal_new = {lvl_sat, 8'd0};
      run_new  = (req_ff.fade_ms != 24'd0) && (cur_base != goal_new);
      cur_new  = run_new ? cur_base : goal_new;
      fin_cur  = is_set ? cur_new : adv_cur;
      fin_run  = is_set ? run_new : adv_run;
      fin_wr   = is_set | wr_ff;
      if (is_set) begin
         chan_wdata.cur_level   = cur_new;
         chan_wdata.start_level = cur_base;
         chan_wdata.goal_level  = lvl_sat;
         chan_wdata.start_time  = req_ff.now_ms;
         chan_wdata.fade_length = req_ff.fade_ms;
      end else begin
         chan_wdata           = chan_ff;
         chan_wdata.cur_level = adv_cur;
      end
      round_sum = 17'(fin_cur) + 17'd128;
   end

   // Sweep counter for clearing the flag stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff       <= '0;
         sweep_clear_ff <= 1'b1;
      end else if (cmd.sweep_start) begin
         sweep_ff       <= '0;
         sweep_clear_ff <= (req_ff.opcode == dmxf_pkg::OP_CLEAR_ALL);
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + IDX_W'(1);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit | cmd.resp_zero | cmd.resp_bad;
      end
      if (cmd.commit) begin
         rsp_ff.level  <= fin_wr ? round_sum[15:8] : 8'd0;
         rsp_ff.fading <= fin_wr & fin_run;
         rsp_ff.status <= 1'b0;
      end else if (cmd.resp_bad) begin
         rsp_ff <= '{level: 8'd0, fading: 1'b0, status: 1'b1};
      end else if (cmd.resp_zero) begin
         rsp_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Channel record store.
   logic [dmxf_pkg::CHAN_W-1:0] chan_rd;
   dmxf_ram #(.WIDTH(dmxf_pkg::CHAN_W), .DEPTH(DEPTH)) u_chan_ram (
      .clock (clock),
      .we    (cmd.commit & (is_set | wr_ff)),
      .waddr (idx),
      .wdata (chan_wdata),
      .raddr (idx),
      .rdata (chan_rd)
   );
   assign chan_q = dmxf_pkg::chan_type'(chan_rd);

   // Fade-running flags, cleared by every sweep.
   dmxf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_run_ram (
      .clock (clock),
      .we    (cmd.sweep_step | cmd.commit),
      .waddr (cmd.sweep_step ? sweep_ff : idx),
      .wdata (cmd.sweep_step ? 1'b0 : fin_run),
      .raddr (idx),
      .rdata (run_q)
   );

   // Channel-written flags, cleared by a clearing sweep.
   dmxf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wr_ram (
      .clock (clock),
      .we    ((cmd.sweep_step & sweep_clear_ff) | cmd.commit),
      .waddr (cmd.sweep_step ? sweep_ff : idx),
      .wdata (cmd.sweep_step ? 1'b0 : fin_wr),
      .raddr (idx),
      .rdata (wr_q)
   );
endmodule
`default_nettype wire

FILE: rtl/dmx_channel_linear_fader_top.sv
// Top level of the per-channel linear fader.
//
//  Channel | Ports                          | Handshake
//  --------+--------------------------------+-----------------------------------
//  request | start, busy, req_data          | taken when start high and busy low
//  result  | rsp_valid, rsp_data            | one-cycle strobe, no back-pressure
//
// A set-target or update item on a channel with a fade still running passes from
// acceptance through decode, read, calc, divider setup, the 16-step serial divider
// and apply to its result strobe; without a division it skips the divider.
// A bad address, stop-all and clear-all are answered from the decode state.
// Stop-all then clears every fade-running flag, clear-all also every channel-written
// flag, in a sweep over CHANNELS*UNIVERSES entries while busy is held high.
// After reset the block sweeps both flag stores before it accepts its first item.
// The result strobe cannot be stalled; the next item is taken once busy falls.
`default_nettype none
module dmx_channel_linear_fader_top #(
   parameter int CHANNELS  = 512,
   parameter int UNIVERSES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dmxf_pkg::req_type req_data,
   output logic                   rsp_valid,
   output dmxf_pkg::rsp_type      rsp_data
);
   dmxf_pkg::cmd_type cmd;
   dmxf_pkg::sts_type sts;

   // Sequencing.
   dmxf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Stores and arithmetic.
   dmxf_dp #(.CHANNELS(CHANNELS), .UNIVERSES(UNIVERSES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`include "dmx_channel_linear_fader_top_assert.svh"

   // An accepted item keeps the block busy in the next cycle.
   `DMXF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result only follows a busy cycle.
   `DMXF_ASSERT_NEXT(a_rsp_after_busy, clock, reset, !busy, !rsp_valid)
   // An address error reports level 0 and no fade.
   `DMXF_ASSERT_SAME(a_bad_fields, clock, reset, rsp_valid && rsp_data.status,
      rsp_data.level == 8'd0 && !rsp_data.fading)
   // A command drives at most one response source at a time.
   `DMXF_ASSERT_SAME(a_one_resp, clock, reset, 1'b1,
      $onehot0({cmd.commit, cmd.resp_zero, cmd.resp_bad}))
endmodule
`default_nettype wire

FILE: sim/dmx_fader_level_checker.sv
// Checker that predicts the fader's results and compares them with the block's output.
module dmx_fader_level_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  dmxf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  dmxf_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CHANNELS = 512;
   localparam int NUM_SLOTS    = 4;
   localparam int NUM_ENTRIES  = NUM_CHANNELS * NUM_SLOTS;

   // Predicted per-channel fade records.
   logic [15:0] level_now   [NUM_ENTRIES];
   logic [15:0] level_from  [NUM_ENTRIES];
   logic [7:0]  level_goal  [NUM_ENTRIES];
   logic [31:0] fade_t0     [NUM_ENTRIES];
   logic [23:0] fade_len    [NUM_ENTRIES];
   bit          is_fading   [NUM_ENTRIES];
   bit          is_written  [NUM_ENTRIES];

   dmxf_pkg::rsp_type expected_levels[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Moves one channel's fade forward to the given time.
   function automatic void advance_fade(int idx, logic [31:0] now);
      logic [31:0] elapsed;
      logic [31:0] span;
      logic [15:0] goal16;
      logic [15:0] from16;
      logic [63:0] step;
      if (!is_written[idx] || !is_fading[idx]) return;
      elapsed = now - fade_t0[idx];
      span    = (fade_len[idx] != 0) ? {8'd0, fade_len[idx]} : 32'd1;
      goal16  = {level_goal[idx], 8'd0};
      from16  = level_from[idx];
      if (elapsed >= span) begin
         level_now[idx] = goal16;
         is_fading[idx] = 1'b0;
      end else if (goal16 >= from16) begin
         step = (64'(goal16 - from16) * 64'(elapsed)) / 64'(span);
         level_now[idx] = from16 + step[15:0];
      end else begin
         step = (64'(from16 - goal16) * 64'(elapsed)) / 64'(span);
         level_now[idx] = from16 - step[15:0];
      end
   endfunction

   // Applies one item to the predicted state and returns its expected result.
   function automatic dmxf_pkg::rsp_type predict_level(dmxf_pkg::req_type it);
      dmxf_pkg::rsp_type res;
      int                idx;
      int                slot;
      logic [15:0]       cur;
      logic [7:0]        goal8;
      res = '0;
      if (it.opcode == dmxf_pkg::OP_STOP_ALL || it.opcode == dmxf_pkg::OP_CLEAR_ALL) begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            is_fading[k] = 1'b0;
            if (it.opcode == dmxf_pkg::OP_CLEAR_ALL) is_written[k] = 1'b0;
         end
         return res;
      end
      if (it.channel_address < 1 || it.channel_address > NUM_CHANNELS) begin
         res.status = 1'b1;
         return res;
      end
      slot = (it.universe_slot >= NUM_SLOTS) ? NUM_SLOTS - 1 : int'(it.universe_slot);
      idx  = slot * NUM_CHANNELS + int'(it.channel_address) - 1;
      advance_fade(idx, it.now_ms);
      if (it.opcode == dmxf_pkg::OP_SET_TARGET) begin
         cur   = is_written[idx] ? level_now[idx] : 16'd0;
         goal8 = (it.target_level > 255) ? 8'd255 : it.target_level[7:0];
         level_from[idx] = cur;
         level_goal[idx] = goal8;
         fade_t0[idx]    = it.now_ms;
         fade_len[idx]   = it.fade_ms;
         is_fading[idx]  = (it.fade_ms != 0) && (cur != {goal8, 8'd0});
         level_now[idx]  = is_fading[idx] ? cur : {goal8, 8'd0};
         is_written[idx] = 1'b1;
      end
      if (is_written[idx]) begin
         res.level  = 8'((17'(level_now[idx]) + 17'd128) >> 8);
         res.fading = is_fading[idx];
      end
      return res;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Results are compared before a newly accepted item is predicted.
   always @(posedge clock) begin
      dmxf_pkg::rsp_type want;
      if (reset) begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            is_fading[k]  = 1'b0;
            is_written[k] = 1'b0;
         end
         expected_levels.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_data.level !== want.level)
                  report_mismatch("level", rsp_data.level, want.level);
               if (rsp_data.fading !== want.fading)
                  report_mismatch("fading", rsp_data.fading, want.fading);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if (start && !busy) expected_levels.push_back(predict_level(req_data));
      end
      pending <= expected_levels.size();
   end

endmodule

FILE: sim/dmx_channel_linear_fader_top_tb.sv
// Testbench top that drives items into the fader and gives the verdict.
module dmx_channel_linear_fader_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 10000;
   localparam int RANDOM_ITEMS = 750;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   dmxf_pkg::req_type req_data;
   logic              rsp_valid;
   dmxf_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;
   int                quiet_cycles = 0;

   always #5 clock = ~clock;

   dmx_channel_linear_fader_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   dmx_fader_level_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("dmx_channel_linear_fader_top test failed");
            $finish;
         end
      end
   end

   // Presents one item and holds it until the block takes it.
   task automatic send_item(logic [1:0] op, logic [1:0] slot, logic [9:0] addr,
                            logic [9:0] lvl, logic [23:0] fade, logic [31:0] now);
      dmxf_pkg::req_type it;
      it.opcode          = op;
      it.universe_slot   = slot;
      it.channel_address = addr;
      it.target_level    = lvl;
      it.fade_ms         = fade;
      it.now_ms          = now;
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
   endtask

   // Now and then drops start for a random idle gap.
   task automatic maybe_idle(bit allowed);
      if (allowed && $urandom_range(99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Waits until every expected result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [1:0]  pool_slot [8];
      logic [9:0]  pool_addr [8];
      logic [31:0] now_t;
      int          pick;
      int          roll;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed items: field extremes, every opcode and the special cases.
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd0, 10'd1, 10'd0, 24'd0, 32'd0);
      send_item(dmxf_pkg::OP_UPDATE, 2'd0, 10'd1, 10'd0, 24'd0, 32'd5);
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd0, 10'd512, 10'd1023, 24'd0, 32'd10);
      send_item(dmxf_pkg::OP_UPDATE, 2'd0, 10'd0, 10'd0, 24'd0, 32'd10);
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd1, 10'd513, 10'd100, 24'd50, 32'd10);
      send_item(dmxf_pkg::OP_UPDATE, 2'd2, 10'd1023, 10'd1023, 24'hFFFFFF, 32'hFFFFFFFF);
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd0, 10'd512, 10'd0, 24'd1000, 32'd100);
      send_item(dmxf_pkg::OP_UPDATE, 2'd0, 10'd512, 10'd0, 24'd0, 32'd600);
      // Time running backwards finishes the fade.
      send_item(dmxf_pkg::OP_UPDATE, 2'd0, 10'd512, 10'd0, 24'd0, 32'd99);
      // Long fade whose elapsed time wraps past zero.
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd3, 10'd256, 10'd128, 24'hFFFFFF, 32'hFFFFFFF0);
      send_item(dmxf_pkg::OP_UPDATE, 2'd3, 10'd256, 10'd0, 24'd0, 32'h00000010);
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd1, 10'd7, 10'd255, 24'd200, 32'd1000);
      send_item(dmxf_pkg::OP_UPDATE, 2'd1, 10'd7, 10'd0, 24'd0, 32'd1101);
      send_item(dmxf_pkg::OP_STOP_ALL, 2'd3, 10'd1023, 10'd1023, 24'hFFFFFF, 32'hFFFFFFFF);
      // A stopped fade stays frozen.
      send_item(dmxf_pkg::OP_UPDATE, 2'd1, 10'd7, 10'd0, 24'd0, 32'd1199);
      send_item(dmxf_pkg::OP_UPDATE, 2'd3, 10'd256, 10'd0, 24'd0, 32'd500);
      // Fading to the present level jumps at once.
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd0, 10'd1, 10'd0, 24'd300, 32'd2000);
      send_item(dmxf_pkg::OP_CLEAR_ALL, 2'd2, 10'd300, 10'd512, 24'h800000, 32'h80000000);
      // Cleared channels read as level 0.
      send_item(dmxf_pkg::OP_UPDATE, 2'd1, 10'd7, 10'd0, 24'd0, 32'd3000);
      send_item(dmxf_pkg::OP_SET_TARGET, 2'd1, 10'd7, 10'd256, 24'd1, 32'd3000);
      send_item(dmxf_pkg::OP_UPDATE, 2'd1, 10'd7, 10'd0, 24'd0, 32'd3000);
      send_item(dmxf_pkg::OP_UPDATE, 2'd1, 10'd7, 10'd0, 24'd0, 32'd3001);

      // Random part: mostly fades and reads on a small pool of channels.
      for (int k = 0; k < 8; k++) begin
         pool_slot[k] = 2'($urandom_range(3));
         pool_addr[k] = 10'($urandom_range(1, 512));
      end
      now_t = $urandom;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(7);
         roll = $urandom_range(99);
         if (n == 200) drain_results();
         if (roll < 35) begin
            send_item(dmxf_pkg::OP_SET_TARGET, pool_slot[pick], pool_addr[pick],
                      ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(255)),
                      ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(2000)), now_t);
         end else if (roll < 80) begin
            now_t = now_t + $urandom_range(300);
            send_item(dmxf_pkg::OP_UPDATE, pool_slot[pick], pool_addr[pick], 10'($urandom),
                      24'($urandom), now_t);
         end else if (roll < 86) begin
            send_item(2'($urandom_range(1)), 2'($urandom), 10'($urandom), 10'($urandom),
                      24'($urandom), $urandom);
         end else if (roll < 92) begin
            send_item(2'($urandom_range(1)), 2'($urandom),
                      ($urandom_range(3) == 0) ? 10'd0 : 10'($urandom_range(513, 1023)),
                      10'($urandom), 24'($urandom), $urandom);
         end else if (roll < 95) begin
            send_item(dmxf_pkg::OP_UPDATE, pool_slot[pick], pool_addr[pick], 10'd0, 24'd0,
                      now_t - $urandom_range(1, 5000));
         end else begin
            send_item(($urandom_range(2) == 0) ? dmxf_pkg::OP_CLEAR_ALL : dmxf_pkg::OP_STOP_ALL,
                      2'($urandom), 10'($urandom), 10'($urandom), 24'($urandom), $urandom);
         end
         maybe_idle(n < 300 || n > 450);
      end

      // Let the last results arrive, then give the verdict.
      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("dmx_channel_linear_fader_top test passed");
      end else begin
         $display("dmx_channel_linear_fader_top test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/dmxf_pkg.sv
rtl/dmxf_ram.sv
rtl/dmxf_ctrl.sv
rtl/dmxf_dp.sv
rtl/dmx_channel_linear_fader_top.sv
sim/dmx_fader_level_checker.sv
sim/dmx_channel_linear_fader_top_tb.sv
